// ----- hw/rtl/hqe_pkg.sv -----
package hqe_pkg;

    // Field widths
    localparam int SAMPLE_W   = 17;
    localparam int FRAC_W     = 16;
    localparam int QUANT_W    = 17;
    localparam int THR_W      = 17;
    localparam int THR_IDX_W  = 3;
    localparam int THR_CNT_W  = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Q1.16 one, and the number of threshold registers
    localparam logic [THR_W-1:0]     ONE_Q16 = 17'd65536;
    localparam int                   NUM_THR = 5;
    localparam logic [THR_CNT_W-1:0] THR_MAX = 3'd5;

    // Register reset values
    localparam logic [THR_CNT_W-1:0] THR_COUNT_RESET = 3'd5;
    localparam logic [THR_W-1:0]     THR_RESET [NUM_THR] = '{
        17'd6554, 17'd19661, 17'd32768, 17'd45875, 17'd58982
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THR_COUNT = 3'd0,
        REG_THR_A     = 3'd1,
        REG_THR_B     = 3'd2,
        REG_THR_C     = 3'd3,
        REG_THR_D     = 3'd4,
        REG_THR_E     = 3'd5
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_MUL,
        ST_NEED,
        ST_SCAN,
        ST_FRAC,
        ST_DIV1,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Bin store control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } bin_ctl_t;

endpackage

// ----- hw/rtl/hqe_bin_store.sv -----
module hqe_bin_store
    import hqe_pkg::*;
#(
    parameter int BIN_COUNT   = 16,
    parameter int COUNT_WIDTH = 32,
    localparam int BW         = $clog2(BIN_COUNT)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bin_ctl_t               ctl,
    input  logic [BW-1:0]          rd_addr,
    input  logic [BW-1:0]          wr_addr,
    input  logic [COUNT_WIDTH-1:0] wr_data,
    output logic [COUNT_WIDTH-1:0] rd_data
);

    logic [COUNT_WIDTH-1:0] bin_mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [BIN_COUNT-1:0]   vld_reg;
    logic                   rd_vld_reg;

    // Counter storage, registered read
    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            bin_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= bin_mem[rd_addr];
        end
    end

    // Per-bin valid bits; a bin not written since the last clear reads as zero
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (ctl.clr) begin
                vld_reg <= '0;
            end else if (ctl.wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/hqe_divider.sv -----
module hqe_divider #(
    parameter int DW   = 49,
    parameter int QW   = 17,
    localparam int VW   = DW - QW + 1,
    localparam int CNTW = $clog2(QW)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [QW-1:0] quotient
);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   dsh_reg, dsh_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            ge;

    // One restoring step per cycle, quotient bits from the top down
    always_comb begin
        ge        = (rem_reg >= dsh_reg);
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = {divisor, {(QW-1){1'b0}}};
            q_next    = '0;
            cnt_next  = CNTW'(QW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hw/rtl/histogram_quantile_engine.sv -----
// Histogram quantile engine.
// Input channel (s_*): one sample per item in Q1.16; s_tlast marks the last sample of a set.
// Each sample is binned into one of BIN_COUNT saturating counters; the sample count saturates.
// A plain sample goes through accept and bin read, then a read-modify-write of the counter
// through the separate read and write ports of the bin memory.
// On the last sample of a set the engine emits one item per configured threshold on the
// result channel (m_*), then clears the histogram. Per threshold the steps are: multiply,
// target count, a scan of the bins up to the chosen bin (at most BIN_COUNT), setup, the
// shared 17-step divider (skipped for an empty bin), scale down by BIN_COUNT and load of
// the output register. s_tready is low during this work.
// The result sits in an output register; a stalled receiver holds the sequencer only when the
// next result is ready, and after the last result the engine takes samples again right away.
// Config channel (cfg_*): always ready; write only while the engine is idle.
// Reset (aresetn, synchronous, active low) clears the histogram valid bits, the sample count,
// the output valid and loads the threshold registers with their defaults.
module histogram_quantile_engine
    import hqe_pkg::*;
#(
    parameter int BIN_COUNT   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [16:0] sample
    input  logic                  s_tlast,   // set_end
    // Results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [16:0] quantile
    output logic [M_TUSER_W-1:0]  m_tuser,   // [2:0] threshold_index, [3] empty_flag
    output logic                  m_tlast,   // last
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW     = COUNT_WIDTH;
    localparam int BW     = $clog2(BIN_COUNT);
    localparam int AW     = CW + FRAC_W + 1;
    localparam int PROD_W = SAMPLE_W + $clog2(BIN_COUNT + 1);
    localparam int HI_W   = PROD_W - FRAC_W;
    localparam logic [CW-1:0] CNT_MAX = '1;
    localparam logic [BW-1:0] TOP_BIN = BW'(BIN_COUNT - 1);
    // Scale-down by BIN_COUNT: multiply by the rounded-up reciprocal, exact below 2^SCL_W
    localparam int SCL_W  = FRAC_W + BW + 1;
    localparam int RCP_SH = SCL_W + BW;
    localparam int RCP_W  = SCL_W + 1;
    localparam longint unsigned RCP_L =
        ((64'd1 << RCP_SH) + 64'(BIN_COUNT) - 64'd1) / 64'(BIN_COUNT);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

    // Configuration registers
    logic [THR_CNT_W-1:0] thr_count_reg;
    logic [THR_W-1:0]     thr_reg [NUM_THR];

    // Sequencer and datapath registers
    state_t               state_reg, state_next;
    logic [CW-1:0]        total_reg, total_next;
    logic [BW-1:0]        bin_addr_reg, bin_addr_next;
    logic                 set_end_reg, set_end_next;
    logic [THR_IDX_W-1:0] k_reg, k_next;
    logic [AW-1:0]        amount_reg, amount_next;
    logic [CW:0]          need_reg, need_next;
    logic [CW-1:0]        cum_reg, cum_next;
    logic [BW-1:0]        idx_reg, idx_next;
    logic [BW-1:0]        spot_reg, spot_next;
    logic [CW-1:0]        slope_reg, slope_next;
    logic                 empty_reg, empty_next;
    logic [SCL_W-1:0]     scl_reg, scl_next;
    logic [QUANT_W-1:0]   res_reg, res_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic [QUANT_W-1:0]   m_quant_reg, m_quant_next;
    logic [THR_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic                 m_empty_reg, m_empty_next;
    logic                 m_last_reg, m_last_next;

    // Internal wires
    bin_ctl_t             bin_ctl;
    logic [BW-1:0]        bin_rd_addr;
    logic [CW-1:0]        bin_wr_data;
    logic [CW-1:0]        bin_rd_data;
    logic [PROD_W-1:0]    sample_prod;
    logic [HI_W-1:0]      sample_hi;
    logic [BW-1:0]        sample_bin;
    logic [THR_CNT_W-1:0] thr_used;
    logic [THR_W-1:0]     t_sel;
    logic [CW:0]          curr;
    logic                 hit;
    logic [AW-1:0]        base;
    logic [AW-1:0]        num;
    logic                 div_start;
    logic [AW-1:0]        div_dividend;
    logic [CW:0]          div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [QUANT_W-1:0]   div_quot;
    logic [QUANT_W-1:0]   frac;
    logic [2*SCL_W:0]     scl_prod;
    logic                 out_free;
    logic                 res_last;

    hqe_bin_store #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (CW)
    ) u_bins (
        .clk     (aclk),
        .rst_n   (aresetn),
        .ctl     (bin_ctl),
        .rd_addr (bin_rd_addr),
        .wr_addr (bin_addr_reg),
        .wr_data (bin_wr_data),
        .rd_data (bin_rd_data)
    );

    hqe_divider #(
        .DW (AW),
        .QW (QUANT_W)
    ) u_div (
        .clk      (aclk),
        .rst_n    (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Config writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_count_reg <= THR_COUNT_RESET;
            thr_reg       <= THR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THR_COUNT: thr_count_reg <= cfg_data[THR_CNT_W-1:0];
                REG_THR_A:     thr_reg[0]    <= cfg_data[THR_W-1:0];
                REG_THR_B:     thr_reg[1]    <= cfg_data[THR_W-1:0];
                REG_THR_C:     thr_reg[2]    <= cfg_data[THR_W-1:0];
                REG_THR_D:     thr_reg[3]    <= cfg_data[THR_W-1:0];
                REG_THR_E:     thr_reg[4]    <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Bin of the incoming sample; 1.0 and above fold into the top bin
    assign sample_prod = PROD_W'(s_tdata[SAMPLE_W-1:0]) * PROD_W'(BIN_COUNT);
    assign sample_hi   = sample_prod[PROD_W-1:FRAC_W];
    assign sample_bin  = (sample_hi >= HI_W'(BIN_COUNT)) ? TOP_BIN : sample_hi[BW-1:0];

    // Thresholds in use and the current fraction, clamped to 1.0
    assign thr_used = (thr_count_reg > THR_MAX) ? THR_MAX : thr_count_reg;
    assign t_sel    = (thr_reg[k_reg] > ONE_Q16) ? ONE_Q16 : thr_reg[k_reg];
    assign res_last = (THR_IDX_W'(k_reg + 1'b1) == thr_used);

    // Scan step: cumulative count through the current bin
    assign curr = (CW+1)'(cum_reg) + (CW+1)'(bin_rd_data);
    assign hit  = (curr >= need_reg) || (idx_reg == TOP_BIN);

    // Amount above the cumulative count before the chosen bin
    assign base = {1'b0, cum_reg, {FRAC_W{1'b0}}};
    assign num  = (amount_reg > base) ? (amount_reg - base) : '0;
    assign frac = (div_quot > ONE_Q16) ? ONE_Q16 : div_quot;

    // Bin position plus fraction, divided by the bin count
    assign scl_prod = (2*SCL_W+1)'(scl_reg) * (2*SCL_W+1)'(RCP);

    assign bin_wr_data = (bin_rd_data == CNT_MAX) ? CNT_MAX : bin_rd_data + 1'b1;
    assign out_free    = !m_valid_reg || m_tready;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        bin_addr_next = bin_addr_reg;
        set_end_next  = set_end_reg;
        k_next        = k_reg;
        amount_next   = amount_reg;
        need_next     = need_reg;
        cum_next      = cum_reg;
        idx_next      = idx_reg;
        spot_next     = spot_reg;
        slope_next    = slope_reg;
        empty_next    = empty_reg;
        scl_next      = scl_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_quant_next  = m_quant_reg;
        m_idx_next    = m_idx_reg;
        m_empty_next  = m_empty_reg;
        m_last_next   = m_last_reg;
        bin_ctl       = '0;
        bin_rd_addr   = sample_bin;
        div_start     = 1'b0;
        div_dividend  = num;
        div_divisor   = (CW+1)'(slope_reg);
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    bin_ctl.rd_en = 1'b1;
                    bin_addr_next = sample_bin;
                    set_end_next  = s_tlast;
                    state_next    = ST_INC;
                end
            end
            ST_INC: begin
                bin_ctl.wr_en = 1'b1;
                total_next    = (total_reg == CNT_MAX) ? CNT_MAX : total_reg + 1'b1;
                k_next        = '0;
                if (!set_end_reg) begin
                    state_next = ST_IDLE;
                end else if (thr_used == '0) begin
                    // no thresholds: the set still ends
                    total_next  = '0;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                amount_next = AW'(total_reg) * AW'(t_sel);
                state_next  = ST_NEED;
            end
            ST_NEED: begin
                // target count, rounded up
                need_next = amount_reg[AW-1:FRAC_W] + (CW+1)'(|amount_reg[FRAC_W-1:0]);
                cum_next  = '0;
                idx_next  = '0;
                bin_ctl.rd_en = 1'b1;
                bin_rd_addr   = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    spot_next  = idx_reg;
                    slope_next = bin_rd_data;
                    state_next = ST_FRAC;
                end else begin
                    cum_next      = curr[CW-1:0];
                    idx_next      = idx_reg + 1'b1;
                    bin_ctl.rd_en = 1'b1;
                    bin_rd_addr   = idx_reg + 1'b1;
                end
            end
            ST_FRAC: begin
                if (slope_reg == '0) begin
                    // empty bin: fraction is zero, go straight to the scale-down
                    empty_next = 1'b1;
                    scl_next   = SCL_W'({spot_reg, {FRAC_W{1'b0}}});
                    state_next = ST_SCALE;
                end else begin
                    empty_next = 1'b0;
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    scl_next   = SCL_W'({spot_reg, {FRAC_W{1'b0}}}) + SCL_W'(frac);
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                res_next   = scl_prod[RCP_SH +: QUANT_W];
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_quant_next = res_reg;
                    m_idx_next   = k_reg;
                    m_empty_next = empty_reg;
                    m_last_next  = res_last;
                    if (res_last) begin
                        bin_ctl.clr = 1'b1;
                        total_next  = '0;
                        state_next  = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // histogram also clears when a set ends with no thresholds
        if (state_reg == ST_INC && set_end_reg && thr_used == '0) begin
            bin_ctl.clr   = 1'b1;
            bin_ctl.wr_en = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        bin_addr_reg <= bin_addr_next;
        set_end_reg  <= set_end_next;
        k_reg        <= k_next;
        amount_reg   <= amount_next;
        need_reg     <= need_next;
        cum_reg      <= cum_next;
        idx_reg      <= idx_next;
        spot_reg     <= spot_next;
        slope_reg    <= slope_next;
        empty_reg    <= empty_next;
        scl_reg      <= scl_next;
        res_reg      <= res_next;
        m_quant_reg  <= m_quant_next;
        m_idx_reg    <= m_idx_next;
        m_empty_reg  <= m_empty_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_quant_reg);
    assign m_tuser  = {m_empty_reg, m_idx_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // divider is never restarted mid-division
    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // after the last result of a set the count is cleared and samples are taken again
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && res_last)
            |=> (total_reg == '0 && state_reg == ST_IDLE))
        else $error("histogram not cleared after last result");

    // a loaded result belongs to a threshold in use
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |-> (k_reg < thr_used))
        else $error("threshold index out of range");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import hqe_pkg::*;

    localparam int HIST_BINS    = 16;
    localparam int COUNT_W      = 32;
    localparam int DRAIN_CYCLES = 400;   // several result times of the engine
    localparam int LONG_HOLD    = 600;
    localparam int PHASE_ITEMS  = 40;
    localparam int MAX_PRINTS   = 60;

    typedef struct {
        logic [QUANT_W-1:0]   quantile;
        logic [THR_IDX_W-1:0] thr_idx;
        logic                 empty;
        logic                 last;
    } quantile_t;

    // One line of the directed script: a register write or a sample
    typedef struct packed {
        logic               is_cfg;
        cfg_reg_t           reg_sel;
        logic [16:0]        value;
        logic               fin;
        logic               chk;      // first result typed in below
        logic [QUANT_W-1:0] exp_q;
        logic               exp_e;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    histogram_quantile_engine #(
        .BIN_COUNT   (HIST_BINS),
        .COUNT_WIDTH (COUNT_W)
    ) dut (.*);

    // Shadow histogram and registers
    logic [COUNT_W-1:0]   hist [HIST_BINS];
    logic [COUNT_W-1:0]   n_samples;
    logic [THR_CNT_W-1:0] thr_count;
    logic [THR_W-1:0]     thr [NUM_THR];

    quantile_t quantiles_due[$];
    int        errors       = 0;
    int        burst_left   = 0;
    bit        hold_pending = 1'b0;

    script_row_t script [22] = '{
        // defaults after reset
        '{1'b0, REG_THR_COUNT, 17'd0,      1'b1, 1'b1, 17'd409,   1'b0},
        '{1'b0, REG_THR_COUNT, 17'd65536,  1'b1, 1'b1, 17'd61849, 1'b0},
        '{1'b0, REG_THR_COUNT, 17'd131071, 1'b1, 1'b1, 17'd61849, 1'b0},
        '{1'b0, REG_THR_COUNT, 17'd4096,   1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd65535,  1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd32768,  1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd1,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd100,    1'b1, 1'b0, 17'd0,     1'b0},
        // threshold extremes, one above 1.0
        '{1'b1, REG_THR_COUNT, 17'd5,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b1, REG_THR_A,     17'd0,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b1, REG_THR_B,     17'd65536,  1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b1, REG_THR_C,     17'd131071, 1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b1, REG_THR_D,     17'd1,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b1, REG_THR_E,     17'd65535,  1'b0, 1'b0, 17'd0,     1'b0},
        // zero threshold lands on an empty bottom bin
        '{1'b0, REG_THR_COUNT, 17'd65536,  1'b1, 1'b1, 17'd0,     1'b1},
        '{1'b0, REG_THR_COUNT, 17'd0,      1'b1, 1'b1, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd0,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd65536,  1'b1, 1'b0, 17'd0,     1'b0},
        // no thresholds, then count clamped to five
        '{1'b1, REG_THR_COUNT, 17'd0,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd5,      1'b1, 1'b0, 17'd0,     1'b0},
        '{1'b1, REG_THR_COUNT, 17'd7,      1'b0, 1'b0, 17'd0,     1'b0},
        '{1'b0, REG_THR_COUNT, 17'd3000,   1'b1, 1'b0, 17'd0,     1'b0}
    };

    task automatic report_error(string msg);
        if (errors < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Interpolated quantile for one threshold fraction
    function automatic logic [QUANT_W-1:0] interp_quantile(logic [THR_W-1:0] frac_reg,
                                                            output logic empty);
        longint unsigned t, amount, need, cum, running, slope, frac, base, num;
        int  spot;
        bit  found;
        t       = (frac_reg > ONE_Q16) ? 64'(ONE_Q16) : 64'(frac_reg);
        amount  = 64'(n_samples) * t;
        need    = (amount >> 16) + ((amount[15:0] != 0) ? 64'd1 : 64'd0);
        cum     = 0;
        running = 0;
        spot    = HIST_BINS - 1;
        found   = 1'b0;
        for (int i = 0; i < HIST_BINS; i++) begin
            running += 64'(hist[i]);
            if (!found && running >= need) begin
                spot  = i;
                found = 1'b1;
            end
            if (!found)
                cum += 64'(hist[i]);
        end
        // target never reached: top bin, cumulative count below it
        if (!found)
            cum -= 64'(hist[HIST_BINS-1]);
        slope = 64'(hist[spot]);
        if (slope == 0) begin
            empty = 1'b1;
            frac  = 0;
        end else begin
            base  = cum << 16;
            num   = (amount > base) ? amount - base : 64'd0;
            frac  = num / slope;
            if (frac > 64'(ONE_Q16))
                frac = 64'(ONE_Q16);
            empty = 1'b0;
        end
        return QUANT_W'(((64'(spot) << 16) + frac) / 64'(HIST_BINS));
    endfunction

    // Count one accepted sample; on set end queue the quantiles and clear
    function automatic void count_sample(logic [16:0] smp, logic fin, logic chk,
                                         logic [QUANT_W-1:0] exp_q, logic exp_e);
        int        bin;
        int        n;
        quantile_t res;
        bin = int'(smp[16:12]);
        if (bin >= HIST_BINS)
            bin = HIST_BINS - 1;
        if (hist[bin] != '1)
            hist[bin]++;
        if (n_samples != '1)
            n_samples++;
        if (!fin)
            return;
        n = (thr_count > THR_MAX) ? int'(THR_MAX) : int'(thr_count);
        for (int k = 0; k < n; k++) begin
            res.quantile = interp_quantile(thr[k], res.empty);
            res.thr_idx  = THR_IDX_W'(k);
            res.last     = (k == n - 1);
            if (chk && k == 0) begin
                res.quantile = exp_q;
                res.empty    = exp_e;
            end
            quantiles_due.insert(quantiles_due.size(), res);
        end
        for (int i = 0; i < HIST_BINS; i++)
            hist[i] = '0;
        n_samples = '0;
    endfunction

    function automatic void apply_config(cfg_reg_t sel, logic [16:0] val);
        if (sel == REG_THR_COUNT)
            thr_count = val[THR_CNT_W-1:0];
        else
            thr[int'(sel) - int'(REG_THR_A)] = val;
    endfunction

    // Offer one sample; the sender idles between bursts of random length
    task automatic send_sample(logic [16:0] smp, logic fin, logic chk = 1'b0,
                               logic [QUANT_W-1:0] exp_q = '0, logic exp_e = 1'b0);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-17){1'b0}}, smp};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        count_sample(smp, fin, chk, exp_q, exp_e);
    endtask

    // Register write; valid stays high for a following write
    task automatic write_reg(cfg_reg_t sel, logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_config(sel, val);
    endtask

    // Stop sending, wait for every quantile, then let the engine finish clearing
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (quantiles_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [16:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'($urandom_range(65537, 131071));
            3:       return 17'd65535;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [16:0] pick_sample(int mode, int center);
        int v;
        case (mode)
            0: v = ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 131071)
                                               : $urandom_range(0, 65535);
            1: begin
                v = center + $urandom_range(0, 4095);
                if (v > 65535)
                    v = 65535;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 0;
                    1:       v = 65535;
                    2:       v = 65536;
                    default: v = 131071;
                endcase
            end
        endcase
        return 17'(v);
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result ready: rotating stall patterns plus one long hold on request
    initial begin
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold         = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                case ((cyc / 97) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= (cyc % 5) == 0;
                    default: m_tready <= $urandom_range(0, 9) < 8;
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expected quantile
    always @(posedge aclk) begin : result_check
        quantile_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (quantiles_due.size() == 0) begin
                report_error($sformatf("unexpected result quantile=%0d index=%0d",
                                       m_tdata[16:0], m_tuser[2:0]));
            end else begin
                want = quantiles_due.pop_front();
                if (m_tdata[16:0] !== want.quantile)
                    report_error($sformatf("quantile %0d, expected %0d (index %0d)",
                                           m_tdata[16:0], want.quantile, want.thr_idx));
                if (m_tuser[2:0] !== want.thr_idx)
                    report_error($sformatf("threshold index %0d, expected %0d",
                                           m_tuser[2:0], want.thr_idx));
                if (m_tuser[3] !== want.empty)
                    report_error($sformatf("empty flag %0b, expected %0b (index %0d)",
                                           m_tuser[3], want.empty, want.thr_idx));
                if (m_tlast !== want.last)
                    report_error($sformatf("last %0b, expected %0b (index %0d)",
                                           m_tlast, want.last, want.thr_idx));
            end
        end
    end

    // Stimulus
    initial begin
        int counts [7];
        int sent;
        int set_len;
        int mode;
        int center;
        int guard;
        counts = '{1, 6, 3, 0, 7, 2, 5};

        for (int i = 0; i < HIST_BINS; i++)
            hist[i] = '0;
        n_samples = '0;
        thr_count = THR_COUNT_RESET;
        for (int i = 0; i < NUM_THR; i++)
            thr[i] = THR_RESET[i];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed script
        for (int r = 0; r < $size(script); r++) begin
            if (script[r].is_cfg) begin
                if (r == 0 || !script[r-1].is_cfg)
                    wait_drained();
                write_reg(script[r].reg_sel, script[r].value);
                if (r == $size(script) - 1 || !script[r+1].is_cfg)
                    cfg_valid <= 1'b0;
            end else begin
                send_sample(script[r].value, script[r].fin, script[r].chk,
                            script[r].exp_q, script[r].exp_e);
            end
        end

        // Random sets under a new register setting per phase
        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            write_reg(REG_THR_COUNT, 17'(counts[ph]));
            write_reg(REG_THR_A, pick_threshold());
            write_reg(REG_THR_B, pick_threshold());
            write_reg(REG_THR_C, pick_threshold());
            write_reg(REG_THR_D, pick_threshold());
            write_reg(REG_THR_E, pick_threshold());
            cfg_valid <= 1'b0;
            // receiver holds off while sets keep coming
            if (ph == 1)
                hold_pending = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                set_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mode = 0;
                    5, 6, 7, 8:    mode = 1;
                    default:       mode = 2;
                endcase
                center = $urandom_range(0, 65535);
                for (int j = 0; j < set_len; j++)
                    send_sample(pick_sample(mode, center), j == set_len - 1);
                sent += set_len;
            end
        end

        // Drain with a bound, then let the engine settle
        s_tvalid <= 1'b0;
        guard = 0;
        while (quantiles_due.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (quantiles_due.size() != 0)
            report_error($sformatf("%0d expected quantiles never arrived",
                                   quantiles_due.size()));

        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/hqe_pkg.sv
hw/rtl/hqe_bin_store.sv
hw/rtl/hqe_divider.sv
hw/rtl/histogram_quantile_engine.sv
test/testbench.sv
